FILE: sv/beacon_encounter_table_assert.svh
// Assertion macros used by the beacon encounter table back end.
`ifndef BEACON_ENCOUNTER_TABLE_ASSERT_SVH
`define BEACON_ENCOUNTER_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF

// Plain invariant, sampled on clk_i, off while rst_ni is low.
`define BET_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define BET_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BET_ASSERT(lbl, prop, msg)
`define BET_ASSERT_IMPL(lbl, ante, cons, msg)
`define BET_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: sv/bet_pkg.sv
// Types and constants of the beacon encounter table.
package bet_pkg;

  localparam int unsigned DEF_TABLE_DEPTH = 16;
  localparam int unsigned AVATAR_BYTES    = 4;

  localparam logic [31:0] BEACON_MAGIC = 32'h5350_4153;
  localparam logic [7:0]  MIN_FRAME    = 8'd10;
  localparam logic [7:0]  FULL_FRAME   = 8'(10 + AVATAR_BYTES);
  localparam logic [15:0] HITS_MAX     = 16'hFFFF;

  // Command codes on the input channel
  localparam logic [1:0] CMD_RX    = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    ST_HIT     = 3'd0,
    ST_NEW     = 3'd1,
    ST_FULL    = 3'd2,
    ST_FILTER  = 3'd3,
    ST_READ    = 3'd4,
    ST_BADIDX  = 3'd5,
    ST_CLEARED = 3'd6
  } status_e;

  // Work classes handed from front to back
  typedef enum logic [1:0] {
    OP_FILTER,
    OP_CLEAR,
    OP_READ,
    OP_FRAME
  } op_e;

  typedef struct packed {
    op_e         kind;
    logic [47:0] mac;
    logic [31:0] avatar;
    logic [31:0] now;
    logic [3:0]  ridx;
  } op_t;

  typedef struct packed {
    logic [47:0] mac;
    logic [15:0] hits;
    logic [31:0] first_seen;
    logic [31:0] last_seen;
    logic [31:0] avatar;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    status_e     status;
    logic [3:0]  idx;
    entry_t      entry;
    logic [4:0]  total;
    logic        fresh;
  } result_t;

endpackage

FILE: sv/bet_ram.sv
// Generic single-port RAM with registered read.
module bet_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/bet_fifo.sv
// Two-entry queue of classified work between front and back.
module bet_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bet_pkg::op_t  data_i,
  output logic          full_o,
  input  logic          pop_i,
  output bet_pkg::op_t  data_o,
  output logic          empty_o
);
  import bet_pkg::*;

  op_t        mem_q [2];
  logic [1:0] cnt_q;
  logic       wr_q;
  logic       rd_q;
  logic       push_ok;
  logic       pop_ok;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign push_ok = push_i & ~full_o;
  assign pop_ok  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      if (push_ok) begin
        wr_q <= ~wr_q;
      end
      if (pop_ok) begin
        rd_q <= ~rd_q;
      end
      case ({push_ok, pop_ok})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: sv/bet_front.sv
// Front end: own-address register and classification of incoming commands.
module bet_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [47:0]   cfg_wdata_i,
  input  logic [1:0]    cmd_i,
  input  logic [31:0]   magic_word_i,
  input  logic [47:0]   src_mac_i,
  input  logic [31:0]   avatar_word_i,
  input  logic [7:0]    frame_len_i,
  input  logic [31:0]   now_ms_i,
  input  logic [3:0]    read_index_i,
  output bet_pkg::op_t  op_o
);
  import bet_pkg::*;

  logic [47:0] own_addr_q;
  logic        drop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q <= 48'd0;
    end else if (cfg_we_i) begin
      own_addr_q <= cfg_wdata_i;
    end
  end

  // Frames that are too short, carry a foreign magic word or echo our own address
  assign drop = (frame_len_i < MIN_FRAME) || (magic_word_i != BEACON_MAGIC) ||
                (src_mac_i == own_addr_q);

  always_comb begin
    op_o.mac    = src_mac_i;
    op_o.avatar = (frame_len_i < FULL_FRAME) ? 32'd0 : avatar_word_i;
    op_o.now    = now_ms_i;
    op_o.ridx   = read_index_i;
    case (cmd_i)
      CMD_RX:    op_o.kind = drop ? OP_FILTER : OP_FRAME;
      CMD_READ:  op_o.kind = OP_READ;
      CMD_CLEAR: op_o.kind = OP_CLEAR;
      default:   op_o.kind = OP_FILTER;
    endcase
  end

endmodule

FILE: sv/bet_back.sv
// Back end: table scan, update/append, reads and the result register.
`include "beacon_encounter_table_assert.svh"

module bet_back #(
  parameter int unsigned TABLE_DEPTH = bet_pkg::DEF_TABLE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bet_pkg::op_t     q_data_i,
  input  logic             q_empty_i,
  output logic             q_pop_o,
  output bet_pkg::result_t res_o,
  output logic             empty_o,
  input  logic             pop_i
);
  import bet_pkg::*;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned RW    = (CNT_W > 4) ? CNT_W : 4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_READ
  } state_e;

  state_e             state_q, state_d;
  op_t                op_q, op_d;
  logic [IDX_W-1:0]   scan_q, scan_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               fresh_q, fresh_d;
  logic               out_valid_q, out_valid_d;
  result_t            out_q, out_d;

  op_t                cur_op;
  logic [CNT_W-1:0]   scan_next;
  logic               do_miss;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_addr;
  entry_t             ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;
  entry_t             ram_rdata;

  function automatic result_t mk_res(status_e st, logic [3:0] idx, entry_t ent,
                                     logic [4:0] total, logic fresh);
    result_t r;
    r.status = st;
    r.idx    = idx;
    r.entry  = ent;
    r.total  = total;
    r.fresh  = fresh;
    return r;
  endfunction

  bet_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);
  assign cur_op    = (state_q == S_IDLE) ? q_data_i : op_q;
  assign scan_next = CNT_W'(scan_q) + CNT_W'(1);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    scan_d      = scan_q;
    count_d     = count_q;
    fresh_d     = fresh_q;
    out_valid_d = out_valid_q & ~pop_i;
    out_d       = out_q;
    q_pop_o     = 1'b0;
    do_miss     = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = '0;
    ram_wdata   = ram_rdata;

    case (state_q)
      S_IDLE: begin
        // Start only with the result register free
        if (!q_empty_i && !out_valid_q) begin
          q_pop_o = 1'b1;
          op_d    = q_data_i;
          case (q_data_i.kind)
            OP_CLEAR: begin
              fresh_d     = 1'b0;
              out_d       = mk_res(ST_CLEARED, 4'd0, '0, 5'(count_q), 1'b0);
              out_valid_d = 1'b1;
            end
            OP_READ: begin
              if (RW'(q_data_i.ridx) < RW'(count_q)) begin
                ram_addr = IDX_W'(q_data_i.ridx);
                state_d  = S_READ;
              end else begin
                out_d       = mk_res(ST_BADIDX, 4'd0, '0, 5'(count_q), fresh_q);
                out_valid_d = 1'b1;
              end
            end
            OP_FRAME: begin
              if (count_q == '0) begin
                do_miss = 1'b1;
              end else begin
                ram_addr = '0;
                scan_d   = '0;
                state_d  = S_SCAN;
              end
            end
            default: begin
              out_d       = mk_res(ST_FILTER, 4'd0, '0, 5'(count_q), fresh_q);
              out_valid_d = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        // ram_rdata holds the slot at scan_q
        if (ram_rdata.mac == op_q.mac) begin
          ram_wdata.hits      = (ram_rdata.hits != HITS_MAX) ? ram_rdata.hits + 16'd1
                                                             : ram_rdata.hits;
          ram_wdata.last_seen = op_q.now;
          ram_wdata.avatar    = op_q.avatar;
          ram_we              = 1'b1;
          ram_addr            = scan_q;
          fresh_d             = 1'b1;
          out_d               = mk_res(ST_HIT, 4'(scan_q), ram_wdata, 5'(count_q), 1'b1);
          out_valid_d         = 1'b1;
          state_d             = S_IDLE;
        end else if (scan_next < count_q) begin
          ram_addr = IDX_W'(scan_next);
          scan_d   = IDX_W'(scan_next);
        end else begin
          do_miss = 1'b1;
          state_d = S_IDLE;
        end
      end

      S_READ: begin
        out_d       = mk_res(ST_READ, op_q.ridx, ram_rdata, 5'(count_q), fresh_q);
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Miss: append at the fill point unless the table is full
    if (do_miss) begin
      if (count_q == CNT_W'(TABLE_DEPTH)) begin
        out_d = mk_res(ST_FULL, 4'd0, '0, 5'(count_q), fresh_q);
      end else begin
        ram_wdata.mac        = cur_op.mac;
        ram_wdata.hits       = 16'd1;
        ram_wdata.first_seen = cur_op.now;
        ram_wdata.last_seen  = cur_op.now;
        ram_wdata.avatar     = cur_op.avatar;
        ram_we               = 1'b1;
        ram_addr             = IDX_W'(count_q);
        count_d              = count_q + CNT_W'(1);
        fresh_d              = 1'b1;
        out_d                = mk_res(ST_NEW, 4'(count_q), ram_wdata,
                                      5'(count_q + CNT_W'(1)), 1'b1);
      end
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= '0;
      scan_q      <= '0;
      count_q     <= '0;
      fresh_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      scan_q      <= scan_d;
      count_q     <= count_d;
      fresh_q     <= fresh_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign res_o   = out_q;
  assign empty_o = ~out_valid_q;

  `BET_ASSERT(a_count_bound, count_q <= CNT_W'(TABLE_DEPTH), "entry count exceeds table depth")
  `BET_ASSERT_IMPL(a_start_free, q_pop_o, !out_valid_q, "work started with result pending")
  `BET_ASSERT_IMPL(a_scan_range, state_q == S_SCAN, CNT_W'(scan_q) < count_q,
                   "scan beyond valid entries")
  `BET_ASSERT_NEXT(a_write_result, ram_we, out_valid_q, "table write without a result")

endmodule

FILE: sv/beacon_encounter_table.sv
// Top level of the beacon encounter table.
//
// Input channel: a queue-style push/full port; a transaction completes on a
// rising edge with push high and full low. cmd selects receive frame, read
// entry or clear new flag; unknown commands answer as filtered.
// Result channel: empty/pop; the oldest result sits on the result ports while
// empty is low and is consumed on an edge with pop high. Every command gives
// exactly one result, in order.
// Configuration: cfg_we_i writes own_address from cfg_wdata_i; write only
// while the block is idle.
// Path: a command enters a two-entry queue; a filtered, clear or bad-index
// result then goes to the result register; a good read first passes the RAM read.
// A frame scans the valid slots one per cycle through the table RAM port,
// comparing up to TABLE_DEPTH slots, the write-back sharing the last compare.
// That scan sets the sustained frame rate; the back end takes no new command
// until a frame's scan is done.
// Stalls: the back end starts a command only once the result register is
// free; with the result unpopped, two more commands queue and then full rises.
// Reset: table empty, new flag clear, own_address zero; no clearing pass.
module beacon_encounter_table #(
  parameter int unsigned TABLE_DEPTH = bet_pkg::DEF_TABLE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration
  input  logic        cfg_we_i,
  input  logic [47:0] cfg_wdata_i,
  // Command channel
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] magic_word_i,
  input  logic [47:0] src_mac_i,
  input  logic [31:0] avatar_word_i,
  input  logic [7:0]  frame_len_i,
  input  logic [31:0] now_ms_i,
  input  logic [3:0]  read_index_i,
  // Result channel
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status_o,
  output logic [3:0]  entry_index_o,
  output logic [47:0] entry_mac_o,
  output logic [15:0] entry_count_o,
  output logic [31:0] entry_first_seen_o,
  output logic [31:0] entry_last_seen_o,
  output logic [31:0] entry_avatar_o,
  output logic [4:0]  total_entries_o,
  output logic        new_flag_o
);
  import bet_pkg::*;

  op_t     front_op;
  op_t     q_data;
  logic    q_empty;
  logic    q_pop;
  result_t res;

  // Classify at the door: filter checks and short-frame avatar masking
  bet_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_i         (cmd_i),
    .magic_word_i  (magic_word_i),
    .src_mac_i     (src_mac_i),
    .avatar_word_i (avatar_word_i),
    .frame_len_i   (frame_len_i),
    .now_ms_i      (now_ms_i),
    .read_index_i  (read_index_i),
    .op_o          (front_op)
  );

  // Decoupling queue; its full flag is the input channel's back-pressure
  bet_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_op),
    .full_o  (full),
    .pop_i   (q_pop),
    .data_o  (q_data),
    .empty_o (q_empty)
  );

  // Table engine and result register
  bet_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_data_i  (q_data),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .res_o     (res),
    .empty_o   (empty),
    .pop_i     (pop)
  );

  assign status_o           = res.status;
  assign entry_index_o      = res.idx;
  assign entry_mac_o        = res.entry.mac;
  assign entry_count_o      = res.entry.hits;
  assign entry_first_seen_o = res.entry.first_seen;
  assign entry_last_seen_o  = res.entry.last_seen;
  assign entry_avatar_o     = res.entry.avatar;
  assign total_entries_o    = res.total;
  assign new_flag_o         = res.fresh;

endmodule
